// ===== hw/rtl/silence_gated_packet_admission_macros.svh =====
// Assertion macros for the silence-gated packet admission block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SILENCE_GATED_PACKET_ADMISSION_MACROS_SVH
`define SILENCE_GATED_PACKET_ADMISSION_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SGPA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SGPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sgpa_pkg.sv =====
// Shared widths, register indexes, command codes and reset values for the
// silence-gated packet admission block. No dependencies.
package sgpa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int THRESH_W   = 16;
    localparam int POS_W      = 12;
    localparam int COUNT_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PKT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SILENT_TO_STOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FILL          = 3'd4;

    // Beat kinds on the input channel
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESH_RST    = 16'd1024;
    localparam logic [POS_W-1:0]    PKT_LEN_RST   = 12'd320;
    localparam logic [COUNT_W-1:0]  STOP_RUN_RST  = 8'd50;
    localparam logic [COUNT_W-1:0]  MIN_FILL_RST  = 8'd12;
    localparam logic [COUNT_W-1:0]  MAX_FILL_RST  = 8'd150;

    // Result beat payload, highest bit first
    typedef struct packed {
        logic [OUT_DATA_W-15:0] pad;
        logic                   take_error;
        logic                   is_recording;
        logic [COUNT_W-1:0]     queued_packets;
        logic                   packet_ready;
        logic                   notify;
        logic                   oldest_dropped;
        logic                   packet_kept;
    } result_t;

endpackage

// ===== hw/rtl/silence_gated_packet_admission.sv =====
// Silence-gated packet admission: top level, single module.
// Depends on sgpa_pkg and silence_gated_packet_admission_macros.svh.
//
// Takes one beat per clock while s_tready is high: an audio sample
// (s_tuser = 0) or a take command (s_tuser = 1), and returns exactly one
// result beat for each. All state updates for a beat are done in the
// accepting cycle from the state registers, so a new beat can follow every
// cycle while results are taken; the sustained rate is then one beat per
// cycle. A result register backed by a one-entry skid stage decouples the
// two sides, so input is still taken while one result waits; s_tready
// drops only when both are full. Configuration writes take effect at the
// next edge and are meant for idle periods.
`include "silence_gated_packet_admission_macros.svh"

module silence_gated_packet_admission
    import sgpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample (signed)
    input  logic                  s_tuser,   // [0] cmd
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] packet_kept, [1] oldest_dropped,
                                             // [2] notify, [3] packet_ready,
                                             // [11:4] queued_packets,
                                             // [12] is_recording, [13] take_error,
                                             // [15:14] zero
    output logic                  m_tlast    // packet_end
);

    // Configuration registers
    logic [THRESH_W-1:0] thresh_reg;
    logic [POS_W-1:0]    pkt_len_reg;
    logic [COUNT_W-1:0]  stop_run_reg;
    logic [COUNT_W-1:0]  min_fill_reg;
    logic [COUNT_W-1:0]  max_fill_reg;

    // Block state
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               loud_reg,  loud_next;
    logic               rec_reg,   rec_next;
    logic [COUNT_W-1:0] run_reg,   run_next;
    logic [COUNT_W-1:0] queue_reg, queue_next;
    logic               emit_reg,  emit_next;

    // Output register and skid stage
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    out_last_reg, skid_last_reg;

    // Per-beat working values
    logic [MAG_W-1:0]   mag;
    logic               loud_acc;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   pkt_len;
    logic [COUNT_W:0]   queue_inc;
    logic               ended, kept, dropped, terr;
    result_t            result;
    logic               push, pop;

    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= THRESH_RST;
            pkt_len_reg  <= PKT_LEN_RST;
            stop_run_reg <= STOP_RUN_RST;
            min_fill_reg <= MIN_FILL_RST;
            max_fill_reg <= MAX_FILL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SILENCE_THRESHOLD: thresh_reg   <= cfg_data[THRESH_W-1:0];
                REG_SAMPLES_PER_PKT:   pkt_len_reg  <= cfg_data[POS_W-1:0];
                REG_SILENT_TO_STOP:    stop_run_reg <= cfg_data[COUNT_W-1:0];
                REG_MIN_FILL:          min_fill_reg <= cfg_data[COUNT_W-1:0];
                REG_MAX_FILL:          max_fill_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Magnitude of the sample; the most negative value gives 32768
    assign mag = s_tdata[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - {1'b0, s_tdata}
                                     : {1'b0, s_tdata};
    assign loud_acc  = loud_reg || (mag >= {1'b0, thresh_reg});
    assign pos_inc   = pos_reg + POS_W'(1);
    assign pkt_len   = (pkt_len_reg == '0) ? POS_W'(1) : pkt_len_reg;
    assign queue_inc = {1'b0, queue_reg} + (COUNT_W+1)'(1);

    // Next state and result flags for the beat on the input
    always_comb begin
        pos_next   = pos_reg;
        loud_next  = loud_reg;
        rec_next   = rec_reg;
        run_next   = run_reg;
        queue_next = queue_reg;
        emit_next  = emit_reg;
        ended      = 1'b0;
        kept       = 1'b0;
        dropped    = 1'b0;
        terr       = 1'b0;

        if (s_tuser == CMD_TAKE) begin
            // take one packet, or flag that none is ready
            if (emit_reg && queue_reg != '0) begin
                queue_next = queue_reg - COUNT_W'(1);
                if (queue_next == '0 && !rec_reg) begin
                    emit_next = 1'b0;
                end
            end else begin
                terr = 1'b1;
            end
        end else if (pos_inc >= pkt_len) begin
            // packet complete: decide admission
            ended     = 1'b1;
            pos_next  = '0;
            loud_next = 1'b0;
            if (rec_reg) begin
                if (!loud_acc) begin
                    run_next = (run_reg != '1) ? run_reg + COUNT_W'(1) : run_reg;
                    if (run_next >= stop_run_reg) begin
                        rec_next = 1'b0;
                        if (queue_reg == '0) begin
                            emit_next = 1'b0;
                        end
                    end else begin
                        kept = 1'b1;
                    end
                end else begin
                    run_next = '0;
                    kept     = 1'b1;
                end
            end else if (loud_acc) begin
                rec_next = 1'b1;
                run_next = '0;
                kept     = 1'b1;
            end

            // admit to the queue; drop the oldest on overfill
            if (kept) begin
                queue_next = queue_inc[COUNT_W-1:0];
                if (queue_inc >= {1'b0, min_fill_reg}) begin
                    emit_next = 1'b1;
                    if (queue_inc > {1'b0, max_fill_reg}) begin
                        dropped    = 1'b1;
                        queue_next = queue_reg;
                    end
                end
            end
        end else begin
            // packet still open: advance position, hold loudness
            pos_next  = pos_inc;
            loud_next = loud_acc;
        end
    end

    // Assemble the result beat
    always_comb begin
        result                = '0;
        result.packet_kept    = kept;
        result.oldest_dropped = dropped;
        result.notify         = kept && emit_next;
        result.packet_ready   = emit_next && (queue_next != '0);
        result.queued_packets = queue_next;
        result.is_recording   = rec_next;
        result.take_error     = terr;
    end

    // Advance state on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            loud_reg  <= 1'b0;
            rec_reg   <= 1'b0;
            run_reg   <= '0;
            queue_reg <= '0;
            emit_reg  <= 1'b0;
        end else if (push) begin
            pos_reg   <= pos_next;
            loud_reg  <= loud_next;
            rec_reg   <= rec_next;
            run_reg   <= run_next;
            queue_reg <= queue_next;
            emit_reg  <= emit_next;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end else begin
                out_data_reg <= result;
                out_last_reg <= ended;
            end
        end else if (push) begin
            skid_data_reg <= result;
            skid_last_reg <= ended;
        end
    end

    // Checks
    `SGPA_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid stage holds a beat while the output register is empty")
    `SGPA_ASSERT_NEXT(a_push_shows, aclk, aresetn, push && !out_valid_reg, out_valid_reg,
        "accepted beat did not reach the output register")
    `SGPA_ASSERT_NEXT(a_skid_drains, aclk, aresetn, pop && skid_valid_reg, !skid_valid_reg,
        "skid stage did not drain after the output was taken")
    `SGPA_ASSERT_IMPL(a_idle_not_emitting, aclk, aresetn,
        !rec_reg && queue_reg == '0, !emit_reg,
        "emitting with an empty queue while not recording")

endmodule
